// ===== hdl/c8ic_pkg.sv =====
// Shared types, constants and the font table for the CHIP-8 instruction core.
package c8ic_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = 12;
    localparam int STACK_DEPTH = 16;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int SCR_XW      = 6;
    localparam int SCR_YW      = 5;
    localparam int FONT_BYTES  = 80;
    localparam logic [11:0] PC_RESET = 12'h200;

    localparam logic [15:0] W_CLS  = 16'h00E0;
    localparam logic [15:0] W_RET  = 16'h00EE;
    localparam logic [7:0]  K_SKP  = 8'h9E;
    localparam logic [7:0]  K_SKNP = 8'hA1;
    localparam logic [3:0]  A_MOV = 4'h0, A_OR = 4'h1, A_AND = 4'h2, A_XOR = 4'h3,
                            A_ADD = 4'h4, A_SUB = 4'h5, A_SHR = 4'h6, A_SUBN = 4'h7,
                            A_SHL = 4'hE;
    localparam logic [7:0]  F_GDT = 8'h07, F_KEY = 8'h0A, F_SDT = 8'h15, F_SST = 8'h18,
                            F_ADI = 8'h1E, F_FNT = 8'h29, F_BCD = 8'h33, F_STR = 8'h55,
                            F_LDR = 8'h65;

    typedef enum logic [1:0] {
        OP_EXEC  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        G_SYS   = 4'h0, G_JP    = 4'h1, G_CALL  = 4'h2, G_SEI   = 4'h3,
        G_SNEI  = 4'h4, G_SER   = 4'h5, G_LDI   = 4'h6, G_ADDI  = 4'h7,
        G_ALU   = 4'h8, G_SNER  = 4'h9, G_LDIDX = 4'hA, G_JP0   = 4'hB,
        G_RND   = 4'hC, G_DRW   = 4'hD, G_KEY   = 4'hE, G_MISC  = 4'hF
    } t_grp;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_F0, S_F1, S_F2, S_RX, S_RY, S_R0, S_EX, S_VF,
        S_CLS, S_DR0, S_DR1, S_DR2, S_BCD, S_ST0, S_ST1, S_LD0, S_LD1,
        S_PX0, S_PX1, S_OUT
    } t_state;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Byte of the preloaded memory image; zero above the font.
    function automatic logic [7:0] init_byte(input logic [MEM_AW-1:0] a);
        logic [7:0] v;
        v = 8'h00;
        if (a < MEM_AW'(FONT_BYTES)) begin
            v = FONT[a[6:0]];
        end
        return v;
    endfunction

endpackage

// ===== hdl/c8ic_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module c8ic_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/chip8_instruction_core.sv =====
// Top level of the CHIP-8 instruction core: sequencer around four RAMs.
// One item is in work at a time; the next is taken while the result waits.
// Reset (i_rst_n low, synchronous) starts a pass that loads the font and
// clears memory, registers, stack and screen; no beat is taken meanwhile.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // addr[11:0], wdata[19:12], keys[35:20], rnd[43:36]
    input  logic [1:0]  i_s_tuser,  // op[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // pc_now, instr, draw, waiting_key, sound_on, pixel, fault
);
    localparam int AW   = c8ic_pkg::MEM_AW;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int XW   = c8ic_pkg::SCR_XW;
    localparam int YW   = c8ic_pkg::SCR_YW;
    localparam int SW   = c8ic_pkg::SCREEN_W;

    c8ic_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_cnt;
    logic [11:0]     r_addr;
    logic [7:0]      r_rnd, r_vx, r_vy, r_v0, r_spr, r_vf, r_dt, r_st;
    logic [15:0]     r_keys, r_w;
    logic [11:0]     r_pc, r_i;
    logic [SP_W-1:0] r_sp;
    logic            r_halt, r_draw, r_wait, r_pix, r_hit, r_fetched;
    logic            r_ovalid;
    logic [39:0]     r_odata;

    // RAM ports
    logic            mem_we, reg_we, stk_we, scr_we;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [7:0]      mem_wd, mem_rd, reg_wd, reg_rd;
    logic [3:0]      reg_wa, reg_ra;
    logic [SA_W-1:0] stk_wa, stk_ra;
    logic [11:0]     stk_wd, stk_rd;
    logic [YW-1:0]   scr_wa, scr_ra;
    logic [SW-1:0]   scr_wd, scr_rd;

    c8ic_ram #(.W(8), .D(c8ic_pkg::MEM_BYTES)) u_mem (
        .i_clk, .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(mem_wd),
        .i_raddr(mem_ra), .o_rdata(mem_rd));
    c8ic_ram #(.W(8), .D(16)) u_regs (
        .i_clk, .i_we(reg_we), .i_waddr(reg_wa), .i_wdata(reg_wd),
        .i_raddr(reg_ra), .o_rdata(reg_rd));
    c8ic_ram #(.W(12), .D(STACK_DEPTH)) u_stack (
        .i_clk, .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));
    c8ic_ram #(.W(SW), .D(c8ic_pkg::SCREEN_H)) u_screen (
        .i_clk, .i_we(scr_we), .i_waddr(scr_wa), .i_wdata(scr_wd),
        .i_raddr(scr_ra), .o_rdata(scr_rd));

    logic in_acc;
    assign in_acc = i_s_tvalid && o_s_tready;

    // Instruction fields
    c8ic_pkg::t_grp grp;
    logic [3:0]  fx, fy, fn;
    logic [7:0]  nn;
    logic [11:0] nnn;
    assign grp = c8ic_pkg::t_grp'(r_w[15:12]);
    assign fx  = r_w[11:8];
    assign fy  = r_w[7:4];
    assign fn  = r_w[3:0];
    assign nn  = r_w[7:0];
    assign nnn = r_w[11:0];

    // Execute decode
    logic        ex_bad, ex_vx_we, ex_vf_we, ex_i_we, ex_push, ex_pop, ex_wait, ex_draw;
    logic        ex_dt_we, ex_st_we;
    logic [7:0]  ex_vx_val, ex_vf_val;
    logic [11:0] ex_npc, ex_i_val, pc2, pc4;
    logic [8:0]  sum9;
    logic [12:0] sum13;
    logic [3:0]  kidx;
    logic        kfound, key_t;
    c8ic_pkg::t_state ex_nst;

    assign pc2   = r_pc + 12'd2;
    assign pc4   = r_pc + 12'd4;
    assign sum9  = {1'b0, r_vx} + {1'b0, r_vy};
    assign sum13 = {1'b0, r_i} + {5'b0, r_vx};
    assign key_t = r_keys[r_vx[3:0]];

    always_comb begin
        kidx   = 4'd0;
        kfound = 1'b0;
        for (int k = 0; k < 16; k++) begin
            if (r_keys[k]) begin
                kidx   = 4'(k);
                kfound = 1'b1;
            end
        end
    end

    always_comb begin
        ex_bad = 1'b0; ex_vx_we = 1'b0; ex_vf_we = 1'b0; ex_i_we = 1'b0;
        ex_push = 1'b0; ex_pop = 1'b0; ex_wait = 1'b0; ex_draw = 1'b0;
        ex_dt_we = 1'b0; ex_st_we = 1'b0;
        ex_vx_val = 8'h00; ex_vf_val = 8'h00;
        ex_npc = pc2; ex_i_val = r_i;
        ex_nst = c8ic_pkg::S_OUT;
        unique case (grp)
            c8ic_pkg::G_SYS: begin
                if (r_w == c8ic_pkg::W_CLS) begin
                    ex_draw = 1'b1;
                    ex_nst  = c8ic_pkg::S_CLS;
                end else if (r_w == c8ic_pkg::W_RET) begin
                    if (r_sp == '0) ex_bad = 1'b1;
                    else begin
                        ex_pop = 1'b1;
                        ex_npc = stk_rd + 12'd2;
                    end
                end else begin
                    ex_bad = 1'b1;
                end
            end
            c8ic_pkg::G_JP: ex_npc = nnn;
            c8ic_pkg::G_CALL: begin
                if (r_sp >= SP_W'(STACK_DEPTH)) ex_bad = 1'b1;
                else begin
                    ex_push = 1'b1;
                    ex_npc  = nnn;
                end
            end
            c8ic_pkg::G_SEI:  if (r_vx == nn) ex_npc = pc4;
            c8ic_pkg::G_SNEI: if (r_vx != nn) ex_npc = pc4;
            c8ic_pkg::G_SER:  if (r_vx == r_vy) ex_npc = pc4;
            c8ic_pkg::G_SNER: if (r_vx != r_vy) ex_npc = pc4;
            c8ic_pkg::G_LDI: begin
                ex_vx_we = 1'b1; ex_vx_val = nn;
            end
            c8ic_pkg::G_ADDI: begin
                ex_vx_we = 1'b1; ex_vx_val = r_vx + nn;
            end
            c8ic_pkg::G_ALU: begin
                ex_vx_we = 1'b1;
                case (fn)
                    c8ic_pkg::A_MOV: ex_vx_val = r_vy;
                    c8ic_pkg::A_OR:  ex_vx_val = r_vx | r_vy;
                    c8ic_pkg::A_AND: ex_vx_val = r_vx & r_vy;
                    c8ic_pkg::A_XOR: ex_vx_val = r_vx ^ r_vy;
                    c8ic_pkg::A_ADD: begin
                        ex_vx_val = sum9[7:0];
                        ex_vf_we = 1'b1; ex_vf_val = {7'd0, sum9[8]};
                    end
                    c8ic_pkg::A_SUB: begin
                        ex_vx_val = r_vx - r_vy;
                        ex_vf_we = 1'b1; ex_vf_val = {7'd0, r_vx >= r_vy};
                    end
                    c8ic_pkg::A_SHR: begin
                        ex_vx_val = {1'b0, r_vx[7:1]};
                        ex_vf_we = 1'b1; ex_vf_val = {7'd0, r_vx[0]};
                    end
                    c8ic_pkg::A_SUBN: begin
                        ex_vx_val = r_vy - r_vx;
                        ex_vf_we = 1'b1; ex_vf_val = {7'd0, r_vy >= r_vx};
                    end
                    c8ic_pkg::A_SHL: begin
                        ex_vx_val = {r_vx[6:0], 1'b0};
                        ex_vf_we = 1'b1; ex_vf_val = {7'd0, r_vx[7]};
                    end
                    default: begin
                        ex_bad = 1'b1; ex_vx_we = 1'b0;
                    end
                endcase
            end
            c8ic_pkg::G_LDIDX: begin
                ex_i_we = 1'b1; ex_i_val = nnn;
            end
            c8ic_pkg::G_JP0: ex_npc = {4'd0, r_v0} + nnn;
            c8ic_pkg::G_RND: begin
                ex_vx_we = 1'b1; ex_vx_val = r_rnd & nn;
            end
            c8ic_pkg::G_DRW: begin
                ex_draw = 1'b1;
                // A zero-row sprite draws nothing but still clears VF.
                if (fn == 4'd0) ex_vf_we = 1'b1;
                else ex_nst = c8ic_pkg::S_DR0;
            end
            c8ic_pkg::G_KEY: begin
                if (nn == c8ic_pkg::K_SKP) begin
                    if (key_t) ex_npc = pc4;
                end else if (nn == c8ic_pkg::K_SKNP) begin
                    if (!key_t) ex_npc = pc4;
                end else begin
                    ex_bad = 1'b1;
                end
            end
            c8ic_pkg::G_MISC: begin
                case (nn)
                    c8ic_pkg::F_GDT: begin
                        ex_vx_we = 1'b1; ex_vx_val = r_dt;
                    end
                    c8ic_pkg::F_KEY: begin
                        if (kfound) begin
                            ex_vx_we = 1'b1; ex_vx_val = {4'd0, kidx};
                        end else begin
                            ex_npc = r_pc; ex_wait = 1'b1;
                        end
                    end
                    c8ic_pkg::F_SDT: ex_dt_we = 1'b1;
                    c8ic_pkg::F_SST: ex_st_we = 1'b1;
                    c8ic_pkg::F_ADI: begin
                        ex_i_we = 1'b1; ex_i_val = sum13[11:0];
                        ex_vf_we = 1'b1; ex_vf_val = {7'd0, sum13[12]};
                    end
                    c8ic_pkg::F_FNT: begin
                        ex_i_we  = 1'b1;
                        ex_i_val = {6'd0, r_vx[3:0], 2'b00} + {8'd0, r_vx[3:0]};
                    end
                    c8ic_pkg::F_BCD: ex_nst = c8ic_pkg::S_BCD;
                    c8ic_pkg::F_STR: ex_nst = c8ic_pkg::S_ST0;
                    c8ic_pkg::F_LDR: ex_nst = c8ic_pkg::S_LD0;
                    default: ex_bad = 1'b1;
                endcase
            end
            default: ex_bad = 1'b1;
        endcase
        if (ex_bad) begin
            ex_vx_we = 1'b0; ex_vf_we = 1'b0; ex_i_we = 1'b0; ex_draw = 1'b0;
            ex_dt_we = 1'b0; ex_st_we = 1'b0; ex_nst = c8ic_pkg::S_OUT;
        end else if (ex_vf_we) begin
            ex_nst = c8ic_pkg::S_VF;
        end
    end

    // Decimal digits of Vx; tens by reciprocal multiply on the remainder.
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_r;
    logic [14:0] bcd_p;
    logic [3:0]  bcd_t, bcd_o;
    logic [7:0]  bcd_dig;
    always_comb begin
        bcd_h = (r_vx >= 8'd200) ? 2'd2 : ((r_vx >= 8'd100) ? 2'd1 : 2'd0);
        bcd_r = 7'(r_vx - 8'(bcd_h) * 8'd100);
        bcd_p = 15'(bcd_r) * 15'd205;
        bcd_t = bcd_p[14:11];
        bcd_o = 4'(bcd_r - 7'(bcd_t) * 7'd10);
        case (r_cnt[1:0])
            2'd0:    bcd_dig = {6'd0, bcd_h};
            2'd1:    bcd_dig = {4'd0, bcd_t};
            default: bcd_dig = {4'd0, bcd_o};
        endcase
    end

    // Sprite row placed on the screen row; bits past the right edge fall off.
    logic [7:0]    spr_rev;
    logic [SW-1:0] spr_mask;
    logic [YW:0]   dr_y;
    logic [AW-1:0] i_off;
    always_comb begin
        for (int b = 0; b < 8; b++) spr_rev[b] = r_spr[7 - b];
    end
    assign spr_mask = SW'(spr_rev) << r_vx[XW-1:0];
    assign dr_y     = {1'b0, r_vy[YW-1:0]} + (YW + 1)'(r_cnt[3:0]);
    assign i_off    = r_i + r_cnt;

    logic loop_end;
    assign loop_end = (r_cnt[3:0] == fx);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            c8ic_pkg::S_CLR:  if (r_cnt == '1) n_state = c8ic_pkg::S_IDLE;
            c8ic_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (c8ic_pkg::t_op'(i_s_tuser))
                        c8ic_pkg::OP_EXEC:
                            n_state = r_halt ? c8ic_pkg::S_OUT : c8ic_pkg::S_F0;
                        c8ic_pkg::OP_READ: n_state = c8ic_pkg::S_PX0;
                        default:           n_state = c8ic_pkg::S_OUT;
                    endcase
                end
            end
            c8ic_pkg::S_F0:  n_state = c8ic_pkg::S_F1;
            c8ic_pkg::S_F1:  n_state = c8ic_pkg::S_F2;
            c8ic_pkg::S_F2:  n_state = c8ic_pkg::S_RX;
            c8ic_pkg::S_RX:  n_state = c8ic_pkg::S_RY;
            c8ic_pkg::S_RY:  n_state = c8ic_pkg::S_R0;
            c8ic_pkg::S_R0:  n_state = c8ic_pkg::S_EX;
            c8ic_pkg::S_EX:  n_state = ex_nst;
            c8ic_pkg::S_VF:  n_state = c8ic_pkg::S_OUT;
            c8ic_pkg::S_CLS: if (r_cnt[YW-1:0] == '1) n_state = c8ic_pkg::S_OUT;
            c8ic_pkg::S_DR0: n_state = dr_y[YW] ? c8ic_pkg::S_VF : c8ic_pkg::S_DR1;
            c8ic_pkg::S_DR1: n_state = c8ic_pkg::S_DR2;
            c8ic_pkg::S_DR2:
                n_state = (r_cnt[3:0] + 4'd1 == fn) ? c8ic_pkg::S_VF : c8ic_pkg::S_DR0;
            c8ic_pkg::S_BCD: if (r_cnt[1:0] == 2'd2) n_state = c8ic_pkg::S_OUT;
            c8ic_pkg::S_ST0: n_state = c8ic_pkg::S_ST1;
            c8ic_pkg::S_ST1: n_state = loop_end ? c8ic_pkg::S_OUT : c8ic_pkg::S_ST0;
            c8ic_pkg::S_LD0: n_state = c8ic_pkg::S_LD1;
            c8ic_pkg::S_LD1: n_state = loop_end ? c8ic_pkg::S_OUT : c8ic_pkg::S_LD0;
            c8ic_pkg::S_PX0: n_state = c8ic_pkg::S_PX1;
            c8ic_pkg::S_PX1: n_state = c8ic_pkg::S_OUT;
            c8ic_pkg::S_OUT: if (!r_ovalid || i_m_tready) n_state = c8ic_pkg::S_IDLE;
            default:         n_state = c8ic_pkg::S_CLR;
        endcase
    end

    // Memory ports and handshake outputs
    always_comb begin
        o_s_tready = 1'b0;
        mem_we = 1'b0; mem_wa = i_off; mem_wd = 8'h00; mem_ra = i_off;
        reg_we = 1'b0; reg_wa = fx; reg_wd = ex_vx_val; reg_ra = fx;
        stk_we = 1'b0; stk_wa = r_sp[SA_W-1:0]; stk_wd = r_pc;
        stk_ra = SA_W'(r_sp - SP_W'(1));
        scr_we = 1'b0; scr_wa = r_cnt[YW-1:0]; scr_wd = '0;
        scr_ra = r_addr[XW+YW-1:XW];
        unique case (r_state)
            c8ic_pkg::S_CLR: begin
                mem_we = 1'b1; mem_wa = r_cnt; mem_wd = c8ic_pkg::init_byte(r_cnt);
                reg_we = (r_cnt < AW'(16)); reg_wa = r_cnt[3:0]; reg_wd = 8'h00;
                stk_we = (r_cnt < AW'(STACK_DEPTH)); stk_wa = r_cnt[SA_W-1:0];
                stk_wd = 12'h000;
                scr_we = (r_cnt < AW'(c8ic_pkg::SCREEN_H));
            end
            c8ic_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                mem_we = in_acc && (c8ic_pkg::t_op'(i_s_tuser) == c8ic_pkg::OP_WRITE);
                mem_wa = i_s_tdata[11:0];
                mem_wd = i_s_tdata[19:12];
            end
            c8ic_pkg::S_F0: mem_ra = r_pc;
            c8ic_pkg::S_F1: mem_ra = r_pc + 12'd1;
            c8ic_pkg::S_F2: reg_ra = fx;
            c8ic_pkg::S_RX: reg_ra = fy;
            c8ic_pkg::S_RY: reg_ra = 4'd0;
            c8ic_pkg::S_EX: begin
                reg_we = ex_vx_we;
                stk_we = ex_push;
            end
            c8ic_pkg::S_VF: begin
                reg_we = 1'b1; reg_wa = 4'hF; reg_wd = r_vf;
            end
            c8ic_pkg::S_CLS: scr_we = 1'b1;
            c8ic_pkg::S_DR1: scr_ra = dr_y[YW-1:0];
            c8ic_pkg::S_DR2: begin
                scr_we = 1'b1; scr_wa = dr_y[YW-1:0]; scr_wd = scr_rd ^ spr_mask;
            end
            c8ic_pkg::S_BCD: begin
                mem_we = 1'b1; mem_wd = bcd_dig;
            end
            c8ic_pkg::S_ST0: reg_ra = r_cnt[3:0];
            c8ic_pkg::S_ST1: begin
                mem_we = 1'b1; mem_wd = reg_rd;
            end
            c8ic_pkg::S_LD1: begin
                reg_we = 1'b1; reg_wa = r_cnt[3:0]; reg_wd = mem_rd;
            end
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c8ic_pkg::S_CLR;
            r_cnt   <= '0;
            r_pc    <= c8ic_pkg::PC_RESET;
            r_i     <= 12'h000;
            r_sp    <= '0;
            r_dt    <= 8'h00;
            r_st    <= 8'h00;
            r_halt  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_m_tvalid && i_m_tready && r_state != c8ic_pkg::S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                c8ic_pkg::S_CLR: r_cnt <= r_cnt + AW'(1);
                c8ic_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_addr    <= i_s_tdata[11:0];
                        r_keys    <= i_s_tdata[35:20];
                        r_rnd     <= i_s_tdata[43:36];
                        r_draw    <= 1'b0;
                        r_wait    <= 1'b0;
                        r_pix     <= 1'b0;
                        r_fetched <= 1'b0;
                        r_cnt     <= '0;
                        if (c8ic_pkg::t_op'(i_s_tuser) == c8ic_pkg::OP_TICK) begin
                            if (r_dt != 8'h00) r_dt <= r_dt - 8'd1;
                            if (r_st != 8'h00) r_st <= r_st - 8'd1;
                        end
                    end
                end
                c8ic_pkg::S_F1: r_w[15:8] <= mem_rd;
                c8ic_pkg::S_F2: begin
                    r_w[7:0]  <= mem_rd;
                    r_fetched <= 1'b1;
                end
                c8ic_pkg::S_RX: r_vx <= reg_rd;
                c8ic_pkg::S_RY: r_vy <= reg_rd;
                c8ic_pkg::S_R0: r_v0 <= reg_rd;
                c8ic_pkg::S_EX: begin
                    r_vf   <= ex_vf_val;
                    r_hit  <= 1'b0;
                    r_draw <= ex_draw;
                    r_wait <= ex_wait;
                    if (ex_bad) r_halt <= 1'b1;
                    else r_pc <= ex_npc;
                    if (ex_i_we) r_i <= ex_i_val;
                    if (ex_dt_we) r_dt <= r_vx;
                    if (ex_st_we) r_st <= r_vx;
                    if (ex_push) r_sp <= r_sp + SP_W'(1);
                    if (ex_pop) r_sp <= r_sp - SP_W'(1);
                end
                c8ic_pkg::S_CLS: r_cnt <= r_cnt + AW'(1);
                c8ic_pkg::S_DR0: if (dr_y[YW]) r_vf <= {7'd0, r_hit};
                c8ic_pkg::S_DR1: r_spr <= mem_rd;
                c8ic_pkg::S_DR2: begin
                    r_hit <= r_hit | (|(scr_rd & spr_mask));
                    r_vf  <= {7'd0, r_hit | (|(scr_rd & spr_mask))};
                    r_cnt <= r_cnt + AW'(1);
                end
                c8ic_pkg::S_BCD: r_cnt <= r_cnt + AW'(1);
                c8ic_pkg::S_ST1, c8ic_pkg::S_LD1: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (loop_end) r_i <= r_i + {8'd0, fx} + 12'd1;
                end
                c8ic_pkg::S_PX1:
                    r_pix <= !r_addr[AW-1] && scr_rd[r_addr[XW-1:0]];
                c8ic_pkg::S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0, r_halt, r_pix, (r_st != 8'h00), r_wait, r_draw,
                                     (r_fetched ? r_w : 16'h0000), r_pc};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // A fault halts the core until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt flag dropped without reset");

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH)) else $error("stack pointer past depth");

    // Program memory changes in idle only through a write beat.
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c8ic_pkg::S_IDLE && !in_acc) |-> !mem_we)
        else $error("memory written while idle");

    // An item that stops the sequencer in a new state leaves it busy next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_tready) else $error("second beat taken during an item");
endmodule
